@@ rtl/core/sfad_pkg.sv @@
// shared types and character codes for the signed fixed-point to ascii decimal unit
// no dependencies

package sfad_pkg;

	// ascii codes of the characters the unit can send
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// command from the converter side to the character sequencer
	typedef struct packed {
		logic start;
		logic neg;
	} sfad_cmd_t;

endpackage

@@ rtl/core/sfad_dabble.sv @@
// bit-serial binary to bcd converter (shift and add-3), one input bit per cycle
// no package dependencies

module sfad_dabble #(
	parameter int VALUE_BITS = 32,
	parameter int BCD_DIGITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [VALUE_BITS-1:0]   mag,
	output logic                    busy,
	output logic                    done,
	output logic [4*BCD_DIGITS-1:0] bcd
);

	localparam int BCD_W = 4 * BCD_DIGITS;
	localparam int CNT_W = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      adj;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			bcd_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				bin_q  <= mag;
				bcd_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
				bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q | done_q;
	assign done = done_q;
	assign bcd  = bcd_q;

	// a new conversion only starts once the previous one has been handed on
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!busy_q && !done_q))
		else $error("conversion started while busy");

endmodule

@@ rtl/core/sfad_emit.sv @@
// character sequencer: one bcd digit per cycle unless stalled, into the output register
// depends on sfad_pkg

module sfad_emit import sfad_pkg::*; #(
	parameter int BCD_DIGITS      = 10,
	parameter int FRACTION_DIGITS = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sfad_cmd_t               cmd,
	input  logic [4*BCD_DIGITS-1:0] bcd,
	output logic                    busy,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              text_char,
	output logic                    last_char
);

	localparam int TOP        = 4 * BCD_DIGITS - 1;
	localparam int INT_DIGITS = BCD_DIGITS - FRACTION_DIGITS;
	localparam int CNT_W      = $clog2(BCD_DIGITS);

	typedef enum logic [2:0] {
		E_IDLE,
		E_SIGN,
		E_INT,
		E_DOT,
		E_FRAC
	} state_t;

	state_t            state_q;
	logic [TOP:0]      dig_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              started_q;
	logic              frac_nz_q;
	logic              out_valid_q;
	logic [7:0]        text_char_q;
	logic              last_char_q;

	logic [3:0] digit;
	logic [7:0] digit_char;
	logic       can_load;
	logic       last_pos;
	logic       show;

	assign digit      = dig_q[TOP -: 4];
	assign digit_char = CHAR_ZERO | {4'h0, digit};
	assign can_load   = !out_valid_q || !out_stall;
	assign last_pos   = (cnt_q == '0);
	// leading zeros of the integer part are skipped, its last digit always goes out
	assign show       = started_q || (digit != 4'h0) || last_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			dig_q       <= '0;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			frac_nz_q   <= 1'b0;
			out_valid_q <= 1'b0;
			text_char_q <= '0;
			last_char_q <= 1'b0;
		end else begin
			if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (cmd.start) begin
						dig_q     <= bcd;
						frac_nz_q <= |bcd[4*FRACTION_DIGITS-1:0];
						cnt_q     <= CNT_W'(INT_DIGITS - 1);
						started_q <= 1'b0;
						state_q   <= cmd.neg ? E_SIGN : E_INT;
					end
				end
				E_SIGN: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						text_char_q <= CHAR_MINUS;
						last_char_q <= 1'b0;
						state_q     <= E_INT;
					end
				end
				E_INT: begin
					if (!show || can_load) begin
						dig_q <= {dig_q[TOP-4:0], 4'h0};
						cnt_q <= cnt_q - 1'b1;
						if (show) begin
							out_valid_q <= 1'b1;
							text_char_q <= digit_char;
							last_char_q <= last_pos && !frac_nz_q;
							started_q   <= 1'b1;
						end
						if (last_pos)
							state_q <= frac_nz_q ? E_DOT : E_IDLE;
					end
				end
				E_DOT: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						text_char_q <= CHAR_DOT;
						last_char_q <= 1'b0;
						cnt_q       <= CNT_W'(FRACTION_DIGITS - 1);
						state_q     <= E_FRAC;
					end
				end
				E_FRAC: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						text_char_q <= digit_char;
						last_char_q <= last_pos;
						dig_q       <= {dig_q[TOP-4:0], 4'h0};
						cnt_q       <= cnt_q - 1'b1;
						if (last_pos)
							state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != E_IDLE);
	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign last_char = last_char_q;

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (state_q == E_IDLE))
		else $error("digits loaded while sequencer busy");

	a_frac_only_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == E_DOT) || (state_q == E_FRAC)) |-> frac_nz_q)
		else $error("fraction sent for a zero fraction");

endmodule

@@ rtl/core/signed_fixed_to_ascii_decimal_unit.sv @@
// top level: signed fixed-point (units of 10^-FRACTION_DIGITS) to ascii decimal text
// depends on sfad_pkg, sfad_dabble, sfad_emit
// sequence: transfer in, then shift-and-add-3 over the VALUE_BITS input bits, hand-over to
//   the sequencer, then the integer bcd positions (skipped zeros included) and the characters
// input: a new number is taken once the previous one has left the sequencer; output
//   stalls hold it back, and the bit-serial converter takes up most of the time per number
// reset: arst_n clears all control state at once; there is no memory to clear

module signed_fixed_to_ascii_decimal_unit import sfad_pkg::*; #(
	parameter int FRACTION_DIGITS = 3,
	parameter int VALUE_BITS      = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [VALUE_BITS-1:0] value_milli,
	// output channel, one character per transfer
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   text_char,
	output logic                         last_char
);

	// decimal digits needed for a magnitude of up to 2^(VALUE_BITS-1),
	// never fewer than the fraction digits plus one integer digit
	localparam int MAG_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
	localparam int BCD_DIGITS = (MAG_DIGITS > FRACTION_DIGITS) ? MAG_DIGITS
	                                                          : FRACTION_DIGITS + 1;

	logic                    in_xfer;
	logic [VALUE_BITS-1:0]   mag;
	logic                    neg_q;
	logic                    dab_busy;
	logic                    dab_done;
	logic [4*BCD_DIGITS-1:0] dab_bcd;
	logic                    emit_busy;
	sfad_cmd_t               cmd;

	// one number at a time; the output register lets the next one in while
	// the final character still waits to be taken
	assign in_stall = dab_busy | emit_busy;
	assign in_xfer  = in_valid & !in_stall;

	// magnitude as unsigned, so the most negative value needs no extra bit
	assign mag = value_milli[VALUE_BITS-1] ? ($unsigned(~value_milli) + VALUE_BITS'(1))
	                                       : $unsigned(value_milli);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
		end else if (in_xfer) begin
			neg_q <= value_milli[VALUE_BITS-1];
		end
	end

	sfad_dabble #(
		.VALUE_BITS (VALUE_BITS),
		.BCD_DIGITS (BCD_DIGITS)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.mag    (mag),
		.busy   (dab_busy),
		.done   (dab_done),
		.bcd    (dab_bcd)
	);

	// hand the finished digits and the sign over to the sequencer
	assign cmd.start = dab_done;
	assign cmd.neg   = neg_q;

	sfad_emit #(
		.BCD_DIGITS      (BCD_DIGITS),
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.bcd       (dab_bcd),
		.busy      (emit_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.text_char (text_char),
		.last_char (last_char)
	);

	// an accepted number keeps the input closed on the following cycle
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input open right after a transfer");

endmodule
